// ===== sv/rle_run_literal_decoder_assert.svh =====
`ifndef RLE_RUN_LITERAL_DECODER_ASSERT_SVH
`define RLE_RUN_LITERAL_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rld check failed");

// next-cycle implication, checked outside reset
`define RLD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rld check failed");

`endif

// ===== sv/rld_pkg.sv =====
package rld_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 14;
  localparam int LitW   = 7;
  localparam int RunLoW = 6;
  localparam int PhaseW = 2;
  localparam int DataW  = 24;
  localparam int UserW  = 2;

  localparam logic [PhaseW-1:0] PH_HEADER    = 2'd0;
  localparam logic [PhaseW-1:0] PH_LITERAL   = 2'd1;
  localparam logic [PhaseW-1:0] PH_RUN_EXT   = 2'd2;
  localparam logic [PhaseW-1:0] PH_RUN_VALUE = 2'd3;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [LitW-1:0]   literal_left;
    logic [CountW-1:0] run_length;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{phase: PH_HEADER, literal_left: '0, run_length: '0};

  typedef struct packed {
    logic [ByteW-1:0]  byte_value;
    logic [CountW-1:0] repeat_count;
    logic              is_run;
    logic              truncated;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

// ===== sv/rld_step.sv =====
module rld_step (
  input  rld_pkg::dec_state_t            state,
  input  logic [rld_pkg::ByteW-1:0]      code_byte,
  input  logic                           block_end,
  output rld_pkg::dec_state_t            state_next,
  output logic                           result_valid,
  output rld_pkg::result_t               result
);
  import rld_pkg::*;

  dec_state_t      nxt;
  logic            have;
  logic [LitW-1:0] lit_dec;
  logic            open_token;

  assign lit_dec = state.literal_left - LitW'(1);

  always_comb begin
    nxt  = state;
    have = 1'b0;
    result = '0;
    unique case (state.phase)
      PH_HEADER: begin
        if (code_byte[7]) begin
          nxt.literal_left = code_byte[LitW-1:0];
          nxt.phase = (code_byte[LitW-1:0] != '0) ? PH_LITERAL : PH_HEADER;
        end else begin
          nxt.run_length = CountW'(code_byte[RunLoW-1:0]);
          nxt.phase = code_byte[6] ? PH_RUN_EXT : PH_RUN_VALUE;
        end
      end
      PH_LITERAL: begin
        have = 1'b1;
        result.byte_value = code_byte;
        result.repeat_count = CountW'(1);
        nxt.literal_left = lit_dec;
        if (lit_dec == '0) begin
          nxt.phase = PH_HEADER;
        end
      end
      PH_RUN_EXT: begin
        nxt.run_length = {code_byte, state.run_length[RunLoW-1:0]};
        nxt.phase = PH_RUN_VALUE;
      end
      PH_RUN_VALUE: begin
        if (state.run_length != '0) begin
          have = 1'b1;
          result.byte_value = code_byte;
          result.repeat_count = state.run_length;
          result.is_run = 1'b1;
        end
        nxt.run_length = '0;
        nxt.phase = PH_HEADER;
      end
      default: begin
        nxt = STATE_RESET;
      end
    endcase

    open_token = (nxt.phase != PH_HEADER);
    result_valid = have;
    if (block_end) begin
      nxt = STATE_RESET;
      if (open_token) begin
        result_valid = 1'b1;
        result.truncated = 1'b1;
      end
    end
    state_next = nxt;
  end

endmodule

// ===== sv/rld_skid.sv =====
module rld_skid (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rld_pkg::result_t      push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rld_pkg::result_t      out_data,
  output rld_pkg::buf_status_t  status
);
  import rld_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || out_ready) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign status    = '{main_valid: main_valid, skid_valid: skid_valid};

endmodule

// ===== sv/rle_run_literal_decoder.sv =====
// run-length stream decoder, one code byte per beat
// input: s_axis stream, tdata[7:0] = code_byte, tlast = block_end
//   a header with bit 7 set opens a literal group of (header & 0x7f) bytes;
//   bit 7 clear opens a run of length header[5:0], extended by a second
//   byte for bits 13:6 when bit 6 is set, followed by the run value byte
// output: m_axis stream, one beat per literal byte or per nonzero run;
//   the run comes out once with its repeat count, not expanded
//   a block ending inside a token gives a beat with truncated set
// a result beat is registered in the output buffer before it reaches m_axis
// throughput: one input beat per cycle while s_axis_tready is high
// stall: a two-entry output buffer holds results; s_axis_tready drops only
//   when both entries are full, so after m_axis stalls input keeps flowing
//   until one more result beat has been taken into the second entry
// reset: rst (sync, active high) returns the decoder to expecting a header
//   and empties the output buffer
module rle_run_literal_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [rld_pkg::ByteW-1:0]   s_axis_tdata,  // [7:0] code_byte
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [rld_pkg::DataW-1:0]   m_axis_tdata,  // [7:0] byte_value, [21:8] repeat_count
  output logic [rld_pkg::UserW-1:0]   m_axis_tuser   // [0] is_run, [1] truncated
);
  import rld_pkg::*;

`include "rle_run_literal_decoder_assert.svh"

  dec_state_t  state;
  dec_state_t  state_next;
  logic        result_valid;
  result_t     result;
  result_t     out_data;
  logic        can_push;
  logic        in_beat;
  buf_status_t buf_status;

  assign s_axis_tready = can_push;
  assign in_beat = s_axis_tvalid && can_push;

  rld_step u_step (
    .state        (state),
    .code_byte    (s_axis_tdata),
    .block_end    (s_axis_tlast),
    .state_next   (state_next),
    .result_valid (result_valid),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (in_beat) begin
      state <= state_next;
    end
  end

  rld_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (in_beat && result_valid),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .status    (buf_status)
  );

  assign m_axis_tdata = {2'b00, out_data.repeat_count, out_data.byte_value};
  assign m_axis_tuser = {out_data.truncated, out_data.is_run};

  `RLD_ASSERT_NOW(a_skid_behind_main, buf_status.skid_valid, buf_status.main_valid)
  `RLD_ASSERT_NOW(a_literal_nonzero, state.phase == PH_LITERAL, state.literal_left != '0)
  `RLD_ASSERT_NOW(a_header_no_run, state.phase == PH_HEADER, state.run_length == '0)
  `RLD_ASSERT_NEXT(a_block_end_clears, in_beat && s_axis_tlast, state == STATE_RESET)

endmodule

// ===== dv/rle_run_literal_decoder_tb.sv =====
module rle_run_literal_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rld_pkg::*;

  localparam int NumItems   = 1350;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;
  localparam int DrainWait  = 20;
  localparam int MaxPrints  = 40;

  typedef struct {
    logic [ByteW-1:0] code;
    logic             last;
  } code_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ByteW-1:0]  s_axis_tdata = '0;   // [7:0] code_byte
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DataW-1:0]  m_axis_tdata;         // [7:0] byte_value, [21:8] repeat_count
  logic [UserW-1:0]  m_axis_tuser;         // [0] is_run, [1] truncated

  code_beat_t  code_beats[$];
  code_beat_t  next_beat;
  result_t     expected_results[$];
  result_t     got_result;
  result_t     want_result;

  // decoder state mirrored by the predictor
  logic [PhaseW-1:0] dec_phase = PH_HEADER;
  logic [LitW-1:0]   lit_left = '0;
  logic [CountW-1:0] run_len = '0;

  int total_items = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  rle_run_literal_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d beats taken", cycle_cnt, accepted_cnt,
               total_items);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MaxPrints) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  // expected result of one code byte, updates the mirrored state
  task automatic decode_code_byte(input logic [ByteW-1:0] code, input logic last);
    result_t res;
    logic    have;
    res = '0;
    have = 1'b0;
    case (dec_phase)
      PH_HEADER: begin
        if (code[7]) begin
          lit_left = code[6:0];
          dec_phase = (code[6:0] != '0) ? PH_LITERAL : PH_HEADER;
        end else begin
          run_len = {8'd0, code[5:0]};
          dec_phase = code[6] ? PH_RUN_EXT : PH_RUN_VALUE;
        end
      end
      PH_LITERAL: begin
        have = 1'b1;
        res.byte_value = code;
        res.repeat_count = 14'd1;
        lit_left = lit_left - 1'b1;
        if (lit_left == '0) dec_phase = PH_HEADER;
      end
      PH_RUN_EXT: begin
        run_len = {code, run_len[5:0]};
        dec_phase = PH_RUN_VALUE;
      end
      default: begin
        if (run_len != '0) begin
          have = 1'b1;
          res.byte_value = code;
          res.repeat_count = run_len;
          res.is_run = 1'b1;
        end
        run_len = '0;
        dec_phase = PH_HEADER;
      end
    endcase
    if (last) begin
      // block closed inside a token
      if (dec_phase != PH_HEADER) begin
        have = 1'b1;
        res.truncated = 1'b1;
      end
      dec_phase = PH_HEADER;
      lit_left = '0;
      run_len = '0;
    end
    if (have) expected_results = {expected_results, res};
  endtask

  function automatic int load_phase(input int done_cnt);
    if (done_cnt < total_items / 3) return 0;
    if (done_cnt < (2 * total_items) / 3) return 1;
    return 2;
  endfunction

  function automatic int send_gap_pct(input int done_cnt);
    case (load_phase(done_cnt))
      0: return 10;
      1: return 50;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_gap_pct(input int done_cnt);
    case (load_phase(done_cnt))
      0: return 50;
      1: return 10;
      default: return 0;
    endcase
  endfunction

  task automatic push_code(input logic [ByteW-1:0] code, input logic last);
    code_beat_t b;
    b.code = code;
    b.last = last;
    code_beats = {code_beats, b};
  endtask

  // one encoded block of well-formed tokens, sometimes with noise or cut short
  task automatic add_block();
    logic [ByteW-1:0] blk[$];
    int ntok;
    int kind;
    int len;
    int keep;
    ntok = $urandom_range(1, 6);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
        blk = {blk, 8'h80 | 8'(len)};
        repeat (len) blk = {blk, 8'($urandom_range(0, 255))};
      end else if (kind < 75) begin
        blk = {blk, {2'b00, 6'($urandom_range(0, 63))}};
        blk = {blk, 8'($urandom_range(0, 255))};
      end else if (kind < 93) begin
        blk = {blk, {2'b01, 6'($urandom_range(0, 63))}};
        blk = {blk, 8'($urandom_range(0, 255))};
        blk = {blk, 8'($urandom_range(0, 255))};
      end else begin
        repeat ($urandom_range(1, 4)) blk = {blk, 8'($urandom_range(0, 255))};
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, blk.size());
      while (blk.size() > keep) void'(blk.pop_back());
    end
    for (int i = 0; i < blk.size(); i++) push_code(blk[i], i == blk.size() - 1);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_code_byte(s_axis_tdata, s_axis_tlast);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (code_beats.size() != 0 && $urandom_range(0, 99) >= send_gap_pct(accepted_cnt)) begin
          next_beat = code_beats.pop_front();
          s_axis_tdata <= next_beat.code;
          s_axis_tlast <= next_beat.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && total_items > 0 && accepted_cnt >= total_items / 6) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_gap_pct(accepted_cnt);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.byte_value = m_axis_tdata[7:0];
      got_result.repeat_count = m_axis_tdata[21:8];
      got_result.is_run = m_axis_tuser[0];
      got_result.truncated = m_axis_tuser[1];
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h count=%0d run=%0b trunc=%0b",
                                  got_result.byte_value, got_result.repeat_count,
                                  got_result.is_run, got_result.truncated));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.byte_value !== want_result.byte_value)
          report_mismatch($sformatf("byte_value %02h, expected %02h",
                                    got_result.byte_value, want_result.byte_value));
        if (got_result.repeat_count !== want_result.repeat_count)
          report_mismatch($sformatf("repeat_count %0d, expected %0d",
                                    got_result.repeat_count, want_result.repeat_count));
        if (got_result.is_run !== want_result.is_run)
          report_mismatch($sformatf("is_run %0b, expected %0b",
                                    got_result.is_run, want_result.is_run));
        if (got_result.truncated !== want_result.truncated)
          report_mismatch($sformatf("truncated %0b, expected %0b",
                                    got_result.truncated, want_result.truncated));
      end
    end
  end

  initial begin
    // empty literal group
    push_code(8'h80, 1'b0);
    // literal bytes at both extremes
    push_code(8'h82, 1'b0);
    push_code(8'h00, 1'b0);
    push_code(8'hFF, 1'b0);
    // short run
    push_code(8'h05, 1'b0);
    push_code(8'hAB, 1'b0);
    // zero-length run
    push_code(8'h00, 1'b0);
    push_code(8'h11, 1'b0);
    // longest extended run
    push_code(8'h7F, 1'b0);
    push_code(8'hFF, 1'b0);
    push_code(8'h5A, 1'b0);
    // extended run of length zero
    push_code(8'h40, 1'b0);
    push_code(8'h00, 1'b0);
    push_code(8'h33, 1'b0);
    // block ends on a finished run
    push_code(8'h3F, 1'b0);
    push_code(8'h00, 1'b1);
    // block ends inside a literal group, carrying the byte
    push_code(8'h83, 1'b0);
    push_code(8'h01, 1'b0);
    push_code(8'h02, 1'b1);
    // block ends after a header: extended run, literal, plain run
    push_code(8'h41, 1'b1);
    push_code(8'h85, 1'b1);
    push_code(8'h05, 1'b1);
    // block ends exactly on the last literal byte
    push_code(8'h81, 1'b0);
    push_code(8'hEE, 1'b1);
    while (code_beats.size() < NumItems) add_block();
    total_items = code_beats.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt != total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
